FILE: rtl/bdac_pkg.sv
`default_nettype none
package bdac_pkg;

	localparam int VAL_W          = 16;
	localparam int CHAR_W         = 6;
	localparam int DIG_W          = 4;
	localparam int HW_DIGITS      = 5;
	localparam int MAX_DIGITS_DEF = 5;
	localparam int CNT_W          = $clog2(HW_DIGITS + 1);
	localparam int DIV_STAGES     = 4;
	localparam int DIV_STEPS      = VAL_W / DIV_STAGES;
	localparam int DAB_STEPS      = VAL_W / 2;
	localparam int BCD_W          = HW_DIGITS * DIG_W;
	localparam int DAB_W          = BCD_W + VAL_W;

	localparam logic [VAL_W-1:0]  LIM_RESET  = VAL_W'(999);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [DAB_W-1:0] dab_t;

endpackage
`default_nettype wire

FILE: rtl/bdac_num_if.sv
`default_nettype none
interface bdac_num_if import bdac_pkg::*; ();
	logic valid;
	logic ready;
	val_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdac_txt_if.sv
`default_nettype none
interface bdac_txt_if import bdac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdac_mod.sv
`default_nettype none
module bdac_mod import bdac_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_valid,
	input  val_t in_value,
	input  val_t lim,
	output logic out_valid,
	output val_t out_value
);

	// restoring remainder: one bit per step, DIV_STEPS steps per stage
	function automatic val_t mod_step(input val_t r, input logic b, input val_t l);
		logic [VAL_W:0] t;
		t = {r, b};
		if (t >= {1'b0, l}) begin
			t = t - {1'b0, l};
		end
		return t[VAL_W-1:0];
	endfunction

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] need_s;
	val_t                  val_s [DIV_STAGES];
	val_t                  rem_s [DIV_STAGES];

	logic [DIV_STAGES-1:0] stg_vld;
	logic [DIV_STAGES-1:0] stg_need;
	val_t                  stg_val [DIV_STAGES];
	val_t                  stg_rem [DIV_STAGES];
	val_t                  nxt_rem [DIV_STAGES];

	always_comb begin
		stg_vld[0]  = in_valid;
		stg_need[0] = in_value > lim;
		stg_val[0]  = in_value;
		stg_rem[0]  = '0;
		for (int k = 1; k < DIV_STAGES; k++) begin
			stg_vld[k]  = vld_s[k-1];
			stg_need[k] = need_s[k-1];
			stg_val[k]  = val_s[k-1];
			stg_rem[k]  = rem_s[k-1];
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		always_comb begin
			val_t r;
			r = stg_rem[k];
			for (int j = 0; j < DIV_STEPS; j++) begin
				r = mod_step(r, stg_val[k][VAL_W-1-k*DIV_STEPS-j], lim);
			end
			nxt_rem[k] = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= stg_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				need_s[k] <= stg_need[k];
				val_s[k]  <= stg_val[k];
				rem_s[k]  <= nxt_rem[k];
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_value = need_s[DIV_STAGES-1] ? rem_s[DIV_STAGES-1] : val_s[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/binary_to_decimal_ascii_wrap_core.sv
// Binary to ASCII decimal converter with a wrap limit.
// num channel: one beat carries a 16-bit unsigned value. txt channel: one
// beat per decimal digit, ASCII code in digit_char, most significant first,
// no leading zeros; last_digit marks the least significant digit. Zero
// gives a single '0'. Values above the limit are reduced modulo the limit.
// cfg_we/cfg_wdata write the limit (reset 999); zero is stored as one.
// Write it only while no beat is in flight.
// A num beat passes 4 remainder stages, 2 double-dabble stages, then the
// digit shifter; the first remainder stage loads on the accepting edge.
// A value gives 1 to 5 digits. The digit shifter sends one digit a cycle
// while txt.ready is high and takes the next value as its last digit goes
// out; it sets the value rate. The pipeline in front takes a value every
// cycle while the shifter keeps up.
// Reset empties all stages; txt.valid is low after reset.
// A stall on txt holds the shown digit; the pipeline fills on and freezes
// whole once its last stage holds a value the shifter cannot take yet, and
// only then does num.ready drop. Nothing is dropped or repeated.
`default_nettype none
module binary_to_decimal_ascii_wrap_core import bdac_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  val_t       cfg_wdata,
	bdac_num_if.sink   num,
	bdac_txt_if.source txt
);

	localparam int               EMIT_MAX   = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
	localparam logic [CNT_W-1:0] EMIT_MAX_C = CNT_W'(EMIT_MAX);

	// one double-dabble pass over DAB_STEPS bits: add 3 to digits >= 5, shift
	function automatic dab_t dabble(input dab_t x);
		dab_t y;
		y = x;
		for (int s = 0; s < DAB_STEPS; s++) begin
			for (int d = 0; d < HW_DIGITS; d++) begin
				if (y[VAL_W+d*DIG_W +: DIG_W] >= DIG_W'(5)) begin
					y[VAL_W+d*DIG_W +: DIG_W] = y[VAL_W+d*DIG_W +: DIG_W] + DIG_W'(3);
				end
			end
			y = y << 1;
		end
		return y;
	endfunction

	// limit register
	val_t wrap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q <= LIM_RESET;
		end else if (cfg_we) begin
			wrap_limit_q <= (cfg_wdata == '0) ? VAL_W'(1) : cfg_wdata;
		end
	end

	// global advance: everything moves unless the last stage is stuck
	logic adv;
	logic load_ok;
	logic mod_vld;
	val_t mod_val;

	assign num.ready = adv;

	bdac_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (num.valid),
		.in_value  (num.value),
		.lim       (wrap_limit_q),
		.out_valid (mod_vld),
		.out_value (mod_val)
	);

	// binary to BCD, two stages of eight shifts
	logic vld_s5, vld_s6;
	dab_t dab_s5, dab_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= mod_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_s5 <= dabble({BCD_W'(0), mod_val});
			dab_s6 <= dabble(dab_s5);
		end
	end

	// significant digit count, clipped to the emit limit
	logic [CNT_W-1:0] cnt;

	always_comb begin
		cnt = CNT_W'(1);
		for (int d = 1; d < HW_DIGITS; d++) begin
			if (dab_s6[VAL_W+d*DIG_W +: DIG_W] != '0) begin
				cnt = CNT_W'(d + 1);
			end
		end
		if (cnt > EMIT_MAX_C) begin
			cnt = EMIT_MAX_C;
		end
	end

	// digit shifter: idx_q walks from the top emitted digit down to zero
	logic [DIG_W-1:0] dig_q [HW_DIGITS];
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;

	assign load_ok = !busy_q || (txt.ready && idx_q == '0);
	assign adv     = !vld_s6 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (vld_s6 && load_ok) begin
			busy_q <= 1'b1;
			idx_q  <= cnt - CNT_W'(1);
		end else if (busy_q && txt.ready) begin
			if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s6 && load_ok) begin
			for (int d = 0; d < HW_DIGITS; d++) begin
				dig_q[d] <= dab_s6[VAL_W+d*DIG_W +: DIG_W];
			end
		end
	end

	assign txt.valid      = busy_q;
	assign txt.digit_char = ASCII_ZERO + CHAR_W'(dig_q[idx_q]);
	assign txt.last_digit = (idx_q == '0);

endmodule
`default_nettype wire

FILE: rtl/bdac_chk.sv
`default_nettype none
module bdac_chk import bdac_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              num_valid,
	input wire              num_ready,
	input wire              txt_valid,
	input wire              txt_ready,
	input wire [CHAR_W-1:0] txt_digit_char,
	input wire              txt_last_digit
);

	logic [CNT_W-1:0] beats_q;
	logic             idle_q;

	// non-last digits sent for the current value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_q <= '0;
		end else if (txt_valid && txt_ready) begin
			beats_q <= txt_last_digit ? '0 : beats_q + CNT_W'(1);
		end
	end

	// true while no value has ever been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 1'b1;
		end else if (num_valid && num_ready) begin
			idle_q <= 1'b0;
		end
	end

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid |-> (txt_digit_char >= ASCII_ZERO && txt_digit_char <= ASCII_ZERO + CHAR_W'(9)))
		else $error("digit_char outside 0..9");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |=> txt_valid && $stable(txt_digit_char) && $stable(txt_last_digit))
		else $error("txt beat changed under stall");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_last_digit |-> beats_q < CNT_W'(HW_DIGITS - 1))
		else $error("too many digits for one value");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q |-> !txt_valid)
		else $error("digit without any value taken");

endmodule

bind binary_to_decimal_ascii_wrap_core bdac_chk u_bdac_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.num_valid      (num.valid),
	.num_ready      (num.ready),
	.txt_valid      (txt.valid),
	.txt_ready      (txt.ready),
	.txt_digit_char (txt.digit_char),
	.txt_last_digit (txt.last_digit)
);
`default_nettype wire

FILE: tb/tb_binary_to_decimal_ascii_wrap_core.sv
`default_nettype none
module tb_binary_to_decimal_ascii_wrap_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bdac_pkg::*;

	// One expected digit beat on the txt channel.
	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	val_t cfg_wdata = '0;

	bdac_num_if num ();
	bdac_txt_if txt ();

	binary_to_decimal_ascii_wrap_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.num(num.sink),
		.txt(txt.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	val_t        value_queue[$];   // values waiting for the driver
	digit_beat_t digit_queue[$];   // digits the block still owes
	val_t        limit_model = LIM_RESET;
	int          err_count = 0;
	int          cycle_count = 0;
	logic        num_busy = 1'b0;  // driver holds a beat on num
	int          src_gap = 0;
	int          snk_gap = 0;

	localparam int CYCLE_LIMIT = 400000;

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Wrap the value, then split it into ASCII digits, most significant first.
	function automatic void predict_digits(val_t v);
		logic [3:0] rev[HW_DIGITS];
		int          n;
		digit_beat_t b;
		logic [31:0] w;
		w = v;
		n = 0;
		if (w > limit_model) w = w % limit_model;
		do begin
			rev[n] = 4'(w % 10);
			w = w / 10;
			n++;
		end while (w != 0 && n < HW_DIGITS);
		for (int k = n - 1; k >= 0; k--) begin
			b.digit_char = ASCII_ZERO + CHAR_W'(rev[k]);
			b.last_digit = (k == 0);
			digit_queue.push_back(b);
		end
	endfunction

	// Source side: one beat in flight at most; prediction at acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (num.valid && num.ready) begin
				predict_digits(num.value);
				src_gap = pick_gap();
			end
			if (!(num.valid && !num.ready)) begin
				if (src_gap > 0 || value_queue.size() == 0) begin
					if (src_gap > 0) src_gap--;
					num.valid <= 1'b0;
					num_busy = 1'b0;
				end else begin
					num.valid <= 1'b1;
					num.value <= value_queue.pop_front();
					num_busy = 1'b1;
				end
			end
		end
	end

	// Sink side: random stalls, compare each digit beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (txt.valid && txt.ready) begin
				if (digit_queue.size() == 0) begin
					$error("unexpected digit beat %h last %b", txt.digit_char, txt.last_digit);
					err_count++;
				end else begin
					digit_beat_t e;
					e = digit_queue.pop_front();
					if (txt.digit_char !== e.digit_char) begin
						$error("digit_char expected %0d got %0d", e.digit_char, txt.digit_char);
						err_count++;
					end
					if (txt.last_digit !== e.last_digit) begin
						$error("last_digit expected %b got %b", e.last_digit, txt.last_digit);
						err_count++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				txt.ready <= 1'b0;
			end else begin
				txt.ready <= 1'b1;
				snk_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_binary_to_decimal_ascii_wrap_core: errors");
			$finish;
		end
	end

	// Wait until every queued value is accepted and every digit has come out.
	task automatic drain();
		while (value_queue.size() != 0 || num_busy || digit_queue.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Register write while idle; the model keeps low 16 bits, zero becomes one.
	task automatic write_limit(val_t lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_model = (lim == 0) ? val_t'(1) : lim;
	endtask

	// Random value: mostly near the limit or small, some anywhere.
	function automatic val_t rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return val_t'($urandom_range(0, 65535));
		if (r < 6) return val_t'($urandom_range(0, 120));
		if (limit_model > 3)
			return val_t'(limit_model + $urandom_range(0, 6) - 3);
		return val_t'($urandom_range(0, 8));
	endfunction

	val_t limits[7] = '{16'd65535, 16'd1, 16'd0, 16'd10, 16'd12345, 16'd100, 16'd999};

	initial begin
		num.valid = 1'b0;
		num.value = '0;
		txt.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset limit of 999.
		value_queue = '{16'd0, 16'd9, 16'd10, 16'd998, 16'd999, 16'd1000, 16'd1998,
			16'd65535, 16'd0, 16'd5, 16'd123};
		drain();
		// Full-width limit: five digits, value equal to the limit kept.
		write_limit(16'd65535);
		value_queue = '{16'd65535, 16'd65534, 16'd10000, 16'd9999, 16'd43690, 16'd21845};
		drain();
		// Limit of zero stores one: everything above one wraps to zero.
		write_limit(16'd0);
		value_queue = '{16'd0, 16'd1, 16'd2, 16'd65535};
		drain();
		write_limit(16'd1);
		value_queue = '{16'd1, 16'd7};
		drain();

		// Random phases, each after a new limit write.
		for (int p = 0; p < 10; p++) begin
			val_t lim;
			lim = (p < 7) ? limits[p] : val_t'($urandom_range(0, 65535));
			write_limit(lim);
			for (int i = 0; i < 47; i++) value_queue.push_back(rand_value());
			drain();
		end

		if (err_count == 0)
			$display("tb_binary_to_decimal_ascii_wrap_core: clean");
		else
			$display("tb_binary_to_decimal_ascii_wrap_core: errors");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/bdac_pkg.sv
rtl/bdac_num_if.sv
rtl/bdac_txt_if.sv
rtl/bdac_mod.sv
rtl/binary_to_decimal_ascii_wrap_core.sv
rtl/bdac_chk.sv
tb/tb_binary_to_decimal_ascii_wrap_core.sv
